// ===== src/pws_pkg.sv =====
// Package for the polyphonic wavetable synthesizer.
// Holds the voice and command types, opcodes, widths and the quarter-wave sine table.
// No dependencies; every other file but pws_checker imports it.
`default_nettype none

package pws_pkg;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned QIDX_W     = IDX_W - 1;
  localparam int unsigned QUARTER    = TABLE_SIZE / 4;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PHASE_W    = IDX_W + FRAC_W;
  localparam int unsigned KEY_W      = 7;
  localparam int unsigned VEL_W      = 7;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned SINE_W     = 16;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned PROD_W     = SINE_W + VEL_W + 1;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int          OUT_OFFSET = 2048;
  localparam int          SAMPLE_MAX = 4095;

  localparam logic [PHASE_W:0] PHASE_LIMIT = {1'b1, {PHASE_W{1'b0}}};
  localparam logic [IDX_W-1:0] HALF_IDX    = {1'b1, {(IDX_W-1){1'b0}}};

  localparam longint unsigned HALF_PI_Q48 = 64'd442139859501778;
  localparam longint unsigned Q48_ONE     = 64'h0001_0000_0000_0000;
  localparam longint unsigned LOW24       = 64'h0000_0000_00FF_FFFF;
  localparam longint unsigned AMPLITUDE   = 64'd32767;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PHASE_W-1:0] inc;
    logic [VEL_W-1:0]   vol;
    logic [PHASE_W-1:0] phase;
  } voice_t;

  typedef struct packed {
    logic               en;
    logic               done;
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [VEL_W-1:0]   vel;
    logic [PHASE_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic run;
  } mix_ctl_t;

  typedef logic [MAG_W-1:0] sine_mag_t;
  typedef sine_mag_t sine_qtr_t [QUARTER+1];

  function automatic longint unsigned mul_q48(longint unsigned a, longint unsigned b);
    longint unsigned ah;
    longint unsigned al;
    longint unsigned bh;
    longint unsigned bl;
    ah = a >> 24;
    al = a & LOW24;
    bh = b >> 24;
    bl = b & LOW24;
    return ah * bh + ((ah * bl + al * bh) >> 24) + ((al * bl) >> 48);
  endfunction

  // Magnitude of the sine at quarter-wave position j, from a Taylor series in Q48.
  function automatic sine_mag_t sine_mag(int unsigned j);
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          sum;
    a = longint'(j) * 4;
    if (a == 0) begin
      return '0;
    end
    if (a == TABLE_SIZE) begin
      return sine_mag_t'(AMPLITUDE);
    end
    x    = (HALF_PI_Q48 * a) / TABLE_SIZE;
    x2   = mul_q48(x, x);
    term = x;
    sum  = $signed(x);
    term = mul_q48(term, x2) / 6;   sum = sum - $signed(term);
    term = mul_q48(term, x2) / 20;  sum = sum + $signed(term);
    term = mul_q48(term, x2) / 42;  sum = sum - $signed(term);
    term = mul_q48(term, x2) / 72;  sum = sum + $signed(term);
    term = mul_q48(term, x2) / 110; sum = sum - $signed(term);
    term = mul_q48(term, x2) / 156; sum = sum + $signed(term);
    term = mul_q48(term, x2) / 210; sum = sum - $signed(term);
    term = mul_q48(term, x2) / 272; sum = sum + $signed(term);
    term = mul_q48(term, x2) / 342; sum = sum - $signed(term);
    term = mul_q48(term, x2) / 420; sum = sum + $signed(term);
    term = mul_q48(term, x2) / 506; sum = sum - $signed(term);
    term = mul_q48(term, x2) / 600; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > $signed(Q48_ONE)) begin
      sum = $signed(Q48_ONE);
    end
    mag = ($unsigned(sum) * AMPLITUDE) >> 48;
    return mag[MAG_W-1:0];
  endfunction

  function automatic sine_qtr_t build_sine();
    sine_qtr_t t;
    for (int unsigned j = 0; j <= QUARTER; j++) begin
      t[j] = sine_mag(j);
    end
    return t;
  endfunction

  localparam sine_qtr_t SINE_QTR = build_sine();

  // Full-wave lookup by quarter-wave symmetry.
  function automatic logic signed [SINE_W-1:0] sine_at(logic [IDX_W-1:0] idx);
    logic                neg;
    logic [IDX_W-2:0]    r;
    logic [IDX_W-1:0]    mirror;
    logic [QIDX_W-1:0]   q;
    logic [MAG_W-1:0]    mag;
    neg    = idx[IDX_W-1];
    r      = idx[IDX_W-2:0];
    mirror = HALF_IDX - {1'b0, r};
    q      = (r > QUARTER) ? mirror[QIDX_W-1:0] : r;
    mag    = SINE_QTR[q];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

// ===== src/pws_cell.sv =====
// One voice cell of the rotating voice ring.
// Holds key, increment, volume and phase of one voice and passes them on when the ring shifts.
// Depends on pws_pkg.
`default_nettype none

module pws_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire pws_pkg::voice_t voice_i,
  output      pws_pkg::voice_t voice_o
);
  import pws_pkg::*;

  voice_t voice_q;
  voice_t voice_d;

  always_comb begin
    voice_d = shift_i ? voice_i : voice_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= '0;
    end else begin
      voice_q <= voice_d;
    end
  end

  assign voice_o = voice_q;

endmodule

`default_nettype wire

// ===== src/pws_proc.sv =====
// Shared voice unit at the tail of the voice ring.
// Applies a note event or a tick to the voice passing by and forms its weighted sine sample.
// Depends on pws_pkg.
`default_nettype none

module pws_proc (
  input  wire pws_pkg::cmd_t                          cmd_i,
  input  wire pws_pkg::voice_t                        voice_i,
  output      pws_pkg::voice_t                        voice_o,
  output      logic                                   hit_o,
  output      logic signed [pws_pkg::PROD_W-1:0]      contrib_o
);
  import pws_pkg::*;

  logic                     active;
  logic                     is_tick;
  logic                     start;
  logic                     release_key;
  logic signed [SINE_W-1:0] sine;
  logic signed [PROD_W-1:0] weighted;
  logic [PHASE_W:0]         phase_sum;
  logic [PHASE_W:0]         phase_wrap;

  always_comb begin
    active      = (voice_i.inc != '0);
    is_tick     = (cmd_i.op == OP_TICK);
    start       = (cmd_i.op == OP_NOTE_ON) && (cmd_i.vel != '0);
    release_key = (cmd_i.op == OP_NOTE_OFF) ||
                  ((cmd_i.op == OP_NOTE_ON) && (cmd_i.vel == '0));
    sine        = sine_at(voice_i.phase[PHASE_W-1:FRAC_W]);
    weighted    = sine * $signed({1'b0, voice_i.vol});
    phase_sum   = {1'b0, voice_i.phase} + {1'b0, voice_i.inc};
    phase_wrap  = (phase_sum >= PHASE_LIMIT) ? (phase_sum - PHASE_LIMIT) : phase_sum;

    voice_o   = voice_i;
    hit_o     = 1'b0;
    contrib_o = '0;
    if (cmd_i.en) begin
      if (is_tick && active) begin
        voice_o.phase = phase_wrap[PHASE_W-1:0];
        contrib_o     = weighted;
      end
      if (start && !cmd_i.done && !active) begin
        voice_o.key = cmd_i.key;
        voice_o.inc = cmd_i.step;
        voice_o.vol = cmd_i.vel;
        hit_o       = 1'b1;
      end
      if (release_key && !cmd_i.done && active && (voice_i.key == cmd_i.key)) begin
        voice_o.key = '0;
        voice_o.inc = '0;
        voice_o.vol = '0;
        hit_o       = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pws_mix.sv =====
// Mixer of the synthesizer: product register, accumulator and output scaling.
// Shifts the sum right by 16, adds the 2048 offset and saturates to 12 bits.
// Depends on pws_pkg.
`default_nettype none

module pws_mix #(
  parameter int unsigned VOICES = 15
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pws_pkg::mix_ctl_t                   ctl_i,
  input  wire logic signed [pws_pkg::PROD_W-1:0]   contrib_i,
  output      logic [pws_pkg::SAMPLE_W-1:0]        sample_o
);
  import pws_pkg::*;

  localparam int unsigned ACC_W = PROD_W + $clog2(VOICES);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W:0]    scaled;

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    if (ctl_i.clear) begin
      prod_d = '0;
      acc_d  = '0;
    end else if (ctl_i.run) begin
      prod_d = contrib_i;
      acc_d  = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
  end

  always_comb begin
    scaled = (ACC_W+1)'(acc_q >>> FRAC_W) + (ACC_W+1)'(OUT_OFFSET);
    if (scaled < 0) begin
      sample_o = '0;
    end else if (scaled > SAMPLE_MAX) begin
      sample_o = SAMPLE_W'(SAMPLE_MAX);
    end else begin
      sample_o = scaled[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/polyphonic_wavetable_synth.sv =====
// Top level of the polyphonic sine wavetable synthesizer.
// Depends on pws_pkg, pws_cell, pws_proc and pws_mix.
//
// The input channel takes one beat per event: op selects a sample tick, a note-on, a
// note-off or a no-op, with key, velocity and phase_step as the note payload. The output
// channel carries one beat with a 12-bit sample for every tick; note events give no beat.
// The voices sit in a ring of VOICES cells. Every accepted beat rotates the ring once,
// one voice a cycle, past one shared voice unit with the sine lookup and the multiplier.
// A note event occupies the block for the scan of the ring; a tick passes the scan, the
// drain step and the emit step before its sample is valid, and the input is ready again
// in the same cycle as the sample appears.
// Reset clears all voices to idle and empties the output register.
// A finished sample waits in the output register while the receiver stalls; note events
// still go through, and a following tick holds in its last step until the sample is taken.
`default_nettype none

module polyphonic_wavetable_synth #(
  parameter int unsigned VOICES = 15
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [pws_pkg::OP_W-1:0]        op_i,
  input  wire logic [pws_pkg::KEY_W-1:0]       key_i,
  input  wire logic [pws_pkg::VEL_W-1:0]       velocity_i,
  input  wire logic [pws_pkg::PHASE_W-1:0]     phase_step_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [pws_pkg::SAMPLE_W-1:0]    sample_o
);
  import pws_pkg::*;

  localparam int unsigned CNT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [CNT_W-1:0] LAST_VOICE = CNT_W'(VOICES - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  op_e                  op_q, op_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [VEL_W-1:0]     vel_q, vel_d;
  logic [PHASE_W-1:0]   step_q, step_d;
  logic                 done_q, done_d;
  logic                 out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]  sample_q, sample_d;

  logic                     accept;
  logic                     shift;
  logic                     hit;
  cmd_t                     cmd;
  mix_ctl_t                 mix_ctl;
  voice_t                   ring [VOICES];
  voice_t                   head_voice;
  logic signed [PROD_W-1:0] contrib;
  logic [SAMPLE_W-1:0]      mix_sample;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign shift      = (state_q == S_SCAN);

  always_comb begin
    cmd.en   = shift;
    cmd.done = done_q;
    cmd.op   = op_q;
    cmd.key  = key_q;
    cmd.vel  = vel_q;
    cmd.step = step_q;
    mix_ctl.clear = accept;
    mix_ctl.run   = (state_q == S_SCAN) || (state_q == S_DRAIN);
  end

  for (genvar i = 0; i < VOICES; i++) begin : g_ring
    pws_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .voice_i ((i == 0) ? head_voice : ring[(i == 0) ? 0 : i - 1]),
      .voice_o (ring[i])
    );
  end

  pws_proc u_proc (
    .cmd_i     (cmd),
    .voice_i   (ring[VOICES-1]),
    .voice_o   (head_voice),
    .hit_o     (hit),
    .contrib_o (contrib)
  );

  pws_mix #(
    .VOICES (VOICES)
  ) u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mix_ctl),
    .contrib_i (contrib),
    .sample_o  (mix_sample)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    key_d       = key_q;
    vel_d       = vel_q;
    step_d      = step_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = op_e'(op_i);
          key_d   = key_i;
          vel_d   = velocity_i;
          step_d  = phase_step_i;
          done_d  = 1'b0;
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          done_d = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_VOICE) begin
          state_d = (op_q == OP_TICK) ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          sample_d    = mix_sample;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    vel_q    <= vel_d;
    step_q   <= step_d;
    sample_q <= sample_d;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

`default_nettype wire

// ===== src/pws_checker.sv =====
// Port-level checker for the polyphonic wavetable synthesizer.
// Watches the handshakes of the top level and is attached to it by the bind below.
`default_nettype none

module pws_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [11:0] sample_o
);

  // A stalled output beat keeps its sample.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sample_o)))
    else $error("output beat changed while stalled");

  // The block works on one beat at a time, so ready drops after every accepted beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready stayed high after an accepted beat");

  // A new sample only appears at the end of a busy period.
  a_sample_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("sample appeared while the block was idle");

endmodule

bind polyphonic_wavetable_synth pws_checker u_pws_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for polyphonic_wavetable_synth, the fifteen-voice sine mixer.
// A predictor class keeps its own voice state and sine table and checks every sample beat.
// Depends on pws_pkg and the synthesizer RTL.

module testbench;
  import pws_pkg::*;

  localparam int unsigned VOICES = 15;

  class mixer_predictor;
    logic [KEY_W-1:0]      key_of   [VOICES];
    logic [PHASE_W-1:0]    step_of  [VOICES];
    logic [VEL_W-1:0]      level_of [VOICES];
    logic [PHASE_W-1:0]    phase_of [VOICES];
    logic signed [15:0]    sine_lut [TABLE_SIZE];
    logic [SAMPLE_W-1:0]   expected_samples [$];
    int                    errors;

    function new();
      errors = 0;
      for (int v = 0; v < VOICES; v++) begin
        key_of[v]   = '0;
        step_of[v]  = '0;
        level_of[v] = '0;
        phase_of[v] = '0;
      end
      for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
        sine_lut[i] = sine_value(i);
      end
    endfunction

    function longint unsigned q48_product(longint unsigned a, longint unsigned b);
      longint unsigned ah;
      longint unsigned al;
      longint unsigned bh;
      longint unsigned bl;
      ah = a >> 24;
      al = a & 64'hFF_FFFF;
      bh = b >> 24;
      bl = b & 64'hFF_FFFF;
      return ah * bh + ((ah * bl + al * bh) >> 24) + ((al * bl) >> 48);
    endfunction

    // Truncated 32767 * sin(2*pi*i/TABLE_SIZE), from a Taylor series in Q48.
    function logic signed [15:0] sine_value(int unsigned i);
      longint unsigned a;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned mag;
      longint          acc;
      bit              neg;
      a   = 64'(i) * 4;
      neg = 1'b0;
      if (a >= 2 * TABLE_SIZE) begin
        neg = 1'b1;
        a   = a - 2 * TABLE_SIZE;
      end
      if (a > TABLE_SIZE) begin
        a = 2 * TABLE_SIZE - a;
      end
      if (a == 0) begin
        return 16'sd0;
      end
      if (a == TABLE_SIZE) begin
        return neg ? -16'sd32767 : 16'sd32767;
      end
      x    = (64'd442139859501778 * a) / TABLE_SIZE;
      x2   = q48_product(x, x);
      term = x;
      acc  = $signed(x);
      for (int k = 1; k <= 12; k++) begin
        term = q48_product(term, x2) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > 64'sh0001_0000_0000_0000) begin
        acc = 64'sh0001_0000_0000_0000;
      end
      mag = ($unsigned(acc) * 64'd32767) >> 48;
      return neg ? -$signed({1'b0, mag[14:0]}) : $signed({1'b0, mag[14:0]});
    endfunction

    function void release_voice(logic [KEY_W-1:0] key);
      for (int v = 0; v < VOICES; v++) begin
        if (step_of[v] != '0 && key_of[v] == key) begin
          step_of[v]  = '0;
          key_of[v]   = '0;
          level_of[v] = '0;
          return;
        end
      end
    endfunction

    function void start_voice(logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel,
                              logic [PHASE_W-1:0] step);
      for (int v = 0; v < VOICES; v++) begin
        if (step_of[v] == '0) begin
          key_of[v]   = key;
          step_of[v]  = step;
          level_of[v] = vel;
          return;
        end
      end
    endfunction

    function void mix_tick();
      longint acc;
      longint mixed;
      acc = 0;
      for (int v = 0; v < VOICES; v++) begin
        if (step_of[v] != '0) begin
          acc = acc + longint'(sine_lut[phase_of[v][PHASE_W-1:FRAC_W]])
                      * longint'(level_of[v]);
          phase_of[v] = phase_of[v] + step_of[v];
        end
      end
      mixed = (acc >>> FRAC_W) + OUT_OFFSET;
      if (mixed < 0) begin
        mixed = 0;
      end else if (mixed > SAMPLE_MAX) begin
        mixed = SAMPLE_MAX;
      end
      expected_samples.push_back(mixed[SAMPLE_W-1:0]);
    endfunction

    function void take_event(op_e op, logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel,
                             logic [PHASE_W-1:0] step);
      case (op)
        OP_TICK: begin
          mix_tick();
        end
        OP_NOTE_ON: begin
          if (vel != '0) begin
            start_voice(key, vel, step);
          end else begin
            release_voice(key);
          end
        end
        OP_NOTE_OFF: begin
          release_voice(key);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample: no beat expected, actual %0d", got);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        $error("sample: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     op_i         = OP_TICK;
  logic [KEY_W-1:0]    key_i        = '0;
  logic [VEL_W-1:0]    velocity_i   = '0;
  logic [PHASE_W-1:0]  phase_step_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [SAMPLE_W-1:0] sample_o;

  mixer_predictor mixer = new();
  bit             bursts_on = 1'b1;

  always #2 clk_i = ~clk_i;

  polyphonic_wavetable_synth #(
    .VOICES(VOICES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .key_i       (key_i),
    .velocity_i  (velocity_i),
    .phase_step_i(phase_step_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o)
  );

  task automatic send_beat(op_e op, logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel,
                           logic [PHASE_W-1:0] step);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    key_i        <= key;
    velocity_i   <= vel;
    phase_step_i <= step;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mixer.take_event(op, key, vel, step);
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        mixer.check_sample(sample_o);
      end
      if (hold > 0) begin
        hold--;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 8);
      end
      out_ready_i <= (hold == 0);
    end
  end

  initial begin
    int                 pick;
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [VEL_W-1:0]   vel;
    logic [PHASE_W-1:0] step;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(OP_TICK, '0, '0, '0);
    send_beat(OP_NONE, '1, '1, '1);
    send_beat(OP_NOTE_ON, 7'd60, 7'd127, 26'h001_0000);
    send_beat(OP_NOTE_ON, 7'd127, 7'd1, '1);
    send_beat(OP_NOTE_ON, 7'd0, 7'd64, '0);
    send_beat(OP_TICK, '0, '0, '0);
    send_beat(OP_NOTE_OFF, 7'd99, '0, '0);
    send_beat(OP_NOTE_ON, 7'd60, 7'd0, '0);
    send_beat(OP_TICK, '1, '1, '1);
    send_beat(OP_NOTE_ON, 7'd60, 7'd100, 26'h002_A000);
    for (int i = 0; i < 13; i++) begin
      send_beat(OP_NOTE_ON, KEY_W'(10 + i), 7'd127, PHASE_W'((i + 1) * 4096));
    end
    send_beat(OP_NOTE_ON, 7'd5, 7'd127, 26'h001_0000);
    send_beat(OP_TICK, '0, '0, '0);
    send_beat(OP_NOTE_OFF, 7'd127, '0, '0);
    send_beat(OP_TICK, '0, '0, '0);

    for (int n = 0; n < 500; n++) begin
      bursts_on = (n < 420) && ((n / 40) % 3 != 2);
      pick = $urandom_range(0, 99);
      key  = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 23));
      vel  = ($urandom_range(0, 7) == 0) ? '0 : VEL_W'($urandom_range(1, 127));
      case ($urandom_range(0, 7))
        0:       step = '0;
        1, 2:    step = PHASE_W'($urandom);
        default: step = PHASE_W'($urandom_range(1, 32'h4_0000));
      endcase
      if (pick < 45) begin
        op = OP_TICK;
      end else if (pick < 70) begin
        op = OP_NOTE_ON;
      end else if (pick < 93) begin
        op = OP_NOTE_OFF;
      end else begin
        op = OP_NONE;
      end
      send_beat(op, key, vel, step);
    end
    in_valid_i <= 1'b0;
    bursts_on = 1'b0;

    while (mixer.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mixer.errors == 0 && mixer.pending() == 0) begin
      $display("** polyphonic_wavetable_synth: PASSED **");
    end else begin
      $display("** polyphonic_wavetable_synth: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("** polyphonic_wavetable_synth: FAILED **");
    $finish;
  end

endmodule
